FILE: design/polyphonic_wavetable_voice_mixer_macros.svh
// ----------------------------------------------------------------------------
// Voice mixer assertion macros
// Shared concurrent assertion forms, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_WAVETABLE_VOICE_MIXER_MACROS_SVH
`define POLYPHONIC_WAVETABLE_VOICE_MIXER_MACROS_SVH

// same-cycle implication
`define PWVM_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pwvm: same-cycle check failed");

// next-cycle implication
`define PWVM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pwvm: next-cycle check failed");

`endif

FILE: design/pwvm_pkg.sv
// ----------------------------------------------------------------------------
// pwvm_pkg
// Types, codes and constants shared by the voice mixer modules.
// ----------------------------------------------------------------------------
package pwvm_pkg;

   // request kinds (req_tuser)
   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_NOTE_ON  = 3'd1;
   localparam logic [2:0] ACT_NOTE_OFF = 3'd2;
   localparam logic [2:0] ACT_SET_STEP = 3'd3;
   localparam logic [2:0] ACT_SET_GAIN = 3'd4;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LVL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LVL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_LVL = 3'd4;

   localparam logic [15:0] GROWTH_RST   = 16'd16400;
   localparam logic [15:0] SHRINK_RST   = 16'd16368;
   localparam logic [15:0] MIN_LVL_RST  = 16'd1;
   localparam logic [15:0] MAX_LVL_RST  = 16'd4096;
   localparam logic [15:0] INIT_LVL_RST = 16'd4;

   localparam logic [15:0] UNITY_Q14 = 16'd16384;

   // mix sum: Q.43 terms, output is floor(sum / 2^28) saturated to 24 bits
   localparam int unsigned SUM_SHIFT  = 28;
   localparam int unsigned SAMPLE_W   = 24;
   localparam int unsigned ACC_BASE_W = 53;

   typedef struct packed {
      logic [15:0] growth;
      logic [15:0] shrink;
      logic [15:0] min_level;
      logic [15:0] max_level;
      logic [15:0] initial_level;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_TICK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // sine table generator, evaluated at elaboration only
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] SINE_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   // p: phase as a fraction of a full turn in units of 2^-32
   function automatic logic signed [15:0] sine_entry(input logic [31:0] p);
      logic [63:0]        t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [65:0] s;
      int                 k;
      t = p[30] ? (ONE_Q30 - 64'(p[29:0])) : 64'(p[29:0]);
      x = (t * PI_HALF_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      s = $signed({2'b00, x});
      for (k = 1; k <= 6; k++) begin
         term = ((term * x2) >> 30) / SINE_DIV[k];
         if (k[0]) begin
            s = s - $signed({2'b00, term});
         end else begin
            s = s + $signed({2'b00, term});
         end
      end
      if (s < 0) begin
         s = '0;
      end
      if (s > $signed({2'b00, ONE_Q30})) begin
         s = $signed({2'b00, ONE_Q30});
      end
      v = ((64'(s) * 64'd32767) + (64'd1 << 29)) >> 30;
      return p[31] ? -16'(v) : 16'(v);
   endfunction

endpackage

FILE: design/pwvm_voice_ram.sv
// ----------------------------------------------------------------------------
// pwvm_voice_ram
// Per-voice state memory: one write, one registered read, zero until written.
// ----------------------------------------------------------------------------
module pwvm_voice_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 53,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_raw_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   // entry valid bits stand in for a reset of the array
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

FILE: design/pwvm_sine_rom.sv
// ----------------------------------------------------------------------------
// pwvm_sine_rom
// One full sine period, Q1.15, registered read.
// ----------------------------------------------------------------------------
module pwvm_sine_rom #(
   parameter int unsigned TABLE_DEPTH = 1024,
   localparam int unsigned PH_W = $clog2(TABLE_DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [PH_W-1:0]     rd_addr,
   output logic signed [15:0]  rd_data
);

   logic signed [15:0] sine_table [TABLE_DEPTH];
   logic signed [15:0] rd_data_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_tab
      localparam logic [63:0] PHASE = (64'(i) << 32) / TABLE_DEPTH;
      assign sine_table[i] = pwvm_pkg::sine_entry(PHASE[31:0]);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sine_table[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pwvm_mix.sv
// ----------------------------------------------------------------------------
// pwvm_mix
// Tick datapath: envelope step, phase advance, write-back and mix sum.
// ----------------------------------------------------------------------------
module pwvm_mix #(
   parameter int unsigned VOICES      = 16,
   parameter int unsigned TABLE_DEPTH = 1024,
   localparam int unsigned PH_W   = $clog2(TABLE_DEPTH),
   localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1,
   localparam int unsigned ACC_W  = pwvm_pkg::ACC_BASE_W + VIDX_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pwvm_pkg::cfg_type       cfg,
   input  logic                    acc_clear,
   // entry read from the voice memory
   input  logic                    b_vld,
   input  logic [VIDX_W-1:0]       b_addr,
   input  logic [15:0]             b_level,
   input  logic                    b_growing,
   input  logic [PH_W-1:0]         b_phase,
   input  logic [PH_W-1:0]         b_step,
   input  logic [15:0]             b_gain,
   // sine lookup
   output logic                    rom_rd_en,
   output logic [PH_W-1:0]         rom_addr,
   input  logic signed [15:0]      rom_data,
   // write-back
   output logic                    wr_en,
   output logic [VIDX_W-1:0]       wr_addr,
   output logic [15:0]             wr_level,
   output logic                    wr_growing,
   output logic [PH_W-1:0]         wr_phase,
   output logic [PH_W-1:0]         wr_step,
   output logic [15:0]             wr_gain,
   output logic signed [ACC_W-1:0] acc,
   output logic                    busy
);

   // stage B
   logic            b_active;
   logic [15:0]     b_factor;
   logic [PH_W:0]   b_phase_sum;
   logic [PH_W-1:0] b_phase_next;

   // stage C
   logic              c_vld_ff, c_active_ff, c_round_ff, c_growing_ff;
   logic [31:0]       c_prod_ff, c_prod_in;
   logic [VIDX_W-1:0] c_addr_ff;
   logic [PH_W-1:0]   c_phase_ff, c_step_ff;
   logic [15:0]       c_gain_ff;
   logic [32:0]       c_sum;
   logic [18:0]       c_lvl_wide;
   logic [15:0]       c_lvl;

   // stages D to F
   logic               d_vld_ff, d_active_ff;
   logic [15:0]        d_lvl_ff, d_gain_ff;
   logic signed [15:0] d_sine_ff;
   logic               e_vld_ff, e_active_ff;
   logic [31:0]        e_lg_ff, e_lg_in;
   logic signed [15:0] e_sine_ff;
   logic signed [32:0] e_lg_s;
   logic               f_vld_ff;
   logic signed [47:0] f_term_ff, f_term_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   assign b_active    = b_level > cfg.min_level;
   assign b_factor    = b_growing ? cfg.growth : cfg.shrink;
   assign b_phase_sum = {1'b0, b_phase} + {1'b0, b_step};
   assign b_phase_next = (b_phase_sum >= (PH_W+1)'(TABLE_DEPTH))
                       ? PH_W'(b_phase_sum - (PH_W+1)'(TABLE_DEPTH))
                       : PH_W'(b_phase_sum);
   assign c_prod_in = b_level * b_factor;

   assign rom_rd_en = b_vld;
   assign rom_addr  = b_phase;

   // round away from the old level: up when growing past unity
   assign c_sum      = {1'b0, c_prod_ff} + (c_round_ff ? 33'd16383 : 33'd0);
   assign c_lvl_wide = c_sum[32:14];
   assign c_lvl      = (c_lvl_wide > {3'b000, cfg.max_level}) ? cfg.max_level
                                                               : c_lvl_wide[15:0];

   assign wr_en      = c_vld_ff & c_active_ff;
   assign wr_addr    = c_addr_ff;
   assign wr_level   = c_lvl;
   assign wr_growing = c_growing_ff;
   assign wr_phase   = c_phase_ff;
   assign wr_step    = c_step_ff;
   assign wr_gain    = c_gain_ff;

   assign e_lg_in   = d_lvl_ff * d_gain_ff;
   assign e_lg_s    = $signed({1'b0, e_lg_ff});
   assign f_term_in = e_active_ff ? (e_lg_s * e_sine_ff) : 48'sd0;
   assign acc_in    = acc_clear ? '0
                    : (f_vld_ff ? (acc_ff + ACC_W'(f_term_ff)) : acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         c_vld_ff <= b_vld;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      c_active_ff  <= b_active;
      c_round_ff   <= b_factor > pwvm_pkg::UNITY_Q14;
      c_growing_ff <= b_growing;
      c_prod_ff    <= c_prod_in;
      c_addr_ff    <= b_addr;
      c_phase_ff   <= b_phase_next;
      c_step_ff    <= b_step;
      c_gain_ff    <= b_gain;
      d_active_ff  <= c_active_ff;
      d_lvl_ff     <= c_lvl;
      d_gain_ff    <= c_gain_ff;
      d_sine_ff    <= rom_data;
      e_active_ff  <= d_active_ff;
      e_lg_ff      <= e_lg_in;
      e_sine_ff    <= d_sine_ff;
      f_term_ff    <= f_term_in;
   end

   assign acc  = acc_ff;
   assign busy = c_vld_ff | d_vld_ff | e_vld_ff | f_vld_ff;

endmodule

FILE: design/polyphonic_wavetable_voice_mixer.sv
// ----------------------------------------------------------------------------
// polyphonic_wavetable_voice_mixer
// Sine voice bank with exponential envelopes, mixed to one saturated sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: a sample tick, note on/off, or a step or
//   gain write for one voice. Only a tick returns a beat on rsp_*: the mixed
//   24-bit sample, used for both stereo channels, and a clip flag.
//   csr_* writes the five envelope registers; write only while idle.
// Timing:
//   A tick walks the voices one per cycle through the voice memory's single
//   read port, then drains the envelope/multiply/accumulate pipe (stages B to F).
//   rsp_tvalid rises once the pipe has drained and the sum is loaded into
//   the output register; req_tready returns in that same cycle. Per-voice
//   commands are a read-modify-write, and the next beat waits for the write.
// Reset:
//   All voices silent with zero step, gain and phase; registers at defaults.
// Stall:
//   The result sits in an output register, so further commands are taken
//   while rsp_tready is low; a second tick finishes its sum and then waits
//   for the output register to free up.
// ----------------------------------------------------------------------------
`include "polyphonic_wavetable_voice_mixer_macros.svh"

module polyphonic_wavetable_voice_mixer #(
   parameter int unsigned VOICES      = 16,
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] voice, [19:4] value, [23:20] zero
   input  logic [2:0]  req_tuser,   // [2:0] action
   // sample channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] sample, signed
   output logic        rsp_tuser,   // [0] clipped
   // register writes
   input  logic                             csr_we,
   input  logic [pwvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                      csr_wdata
);

   localparam int unsigned PH_W   = $clog2(TABLE_DEPTH);
   localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int unsigned ACC_W  = pwvm_pkg::ACC_BASE_W + VIDX_W;
   // voice entry layout, low to high: level, growing, phase, step, gain
   localparam int unsigned OFS_GROW  = 16;
   localparam int unsigned OFS_PHASE = 17;
   localparam int unsigned OFS_STEP  = 17 + PH_W;
   localparam int unsigned OFS_GAIN  = 17 + 2 * PH_W;
   localparam int unsigned ENT_W     = OFS_GAIN + 16;
   localparam int unsigned SAT_LSB   = pwvm_pkg::SUM_SHIFT + pwvm_pkg::SAMPLE_W - 1;

   pwvm_pkg::state_type state_ff, state_in;
   pwvm_pkg::cfg_type   cfg_ff;

   logic [2:0]        req_action;
   logic [3:0]        req_voice;
   logic [15:0]       req_value;
   logic              voice_ok;
   logic              cmd_known;

   logic [VIDX_W-1:0] iss_ff, iss_in;
   logic              issue;
   logic              iss_last;
   logic              b_vld_ff;
   logic [VIDX_W-1:0] b_addr_ff;

   logic              cmd_load;
   logic [2:0]        cmd_action_ff;
   logic [VIDX_W-1:0] cmd_voice_ff;
   logic [15:0]       cmd_value_ff;
   logic              cmd_wr_en;

   logic              ram_rd_en;
   logic [VIDX_W-1:0] ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;
   logic              ram_wr_en;
   logic [VIDX_W-1:0] ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;

   logic [15:0]       ent_level, ent_gain;
   logic              ent_growing;
   logic [PH_W-1:0]   ent_phase, ent_step;

   logic [15:0]       cmd_level, cmd_gain;
   logic              cmd_growing;
   logic [PH_W-1:0]   cmd_phase, cmd_step, step_sat;

   logic              rom_rd_en;
   logic [PH_W-1:0]   rom_addr;
   logic signed [15:0] rom_data;

   logic              mix_wr_en;
   logic [VIDX_W-1:0] mix_wr_addr;
   logic [15:0]       mix_wr_level, mix_wr_gain;
   logic              mix_wr_growing;
   logic [PH_W-1:0]   mix_wr_phase, mix_wr_step;
   logic signed [ACC_W-1:0] mix_acc;
   logic              mix_busy;
   logic              acc_clear;

   logic              rsp_load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_sample_ff, rsp_sample_in;
   logic              rsp_clip_ff, rsp_clip_in;
   logic [ACC_W-1:SAT_LSB] sign_bits;
   logic              fits;

   assign req_action = req_tuser;
   assign req_voice  = req_tdata[3:0];
   assign req_value  = req_tdata[19:4];
   assign voice_ok   = 32'(req_voice) < VOICES;
   assign cmd_known  = (req_action == pwvm_pkg::ACT_NOTE_ON)
                    || (req_action == pwvm_pkg::ACT_NOTE_OFF)
                    || (req_action == pwvm_pkg::ACT_SET_STEP)
                    || (req_action == pwvm_pkg::ACT_SET_GAIN);
   assign iss_last   = iss_ff == VIDX_W'(VOICES - 1);

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwvm_pkg::ST_IDLE;
         iss_ff   <= '0;
         b_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
         b_vld_ff <= issue;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      iss_in      = iss_ff;
      issue       = 1'b0;
      cmd_load    = 1'b0;
      cmd_wr_en   = 1'b0;
      acc_clear   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = iss_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         pwvm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_load = 1'b1;
               if (req_action == pwvm_pkg::ACT_TICK) begin
                  acc_clear = 1'b1;
                  iss_in    = '0;
                  state_in  = pwvm_pkg::ST_TICK;
               end else if (voice_ok && cmd_known) begin
                  // unknown actions and absent voices are dropped here
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = VIDX_W'(req_voice);
                  state_in    = pwvm_pkg::ST_CMD;
               end
            end
         end
         pwvm_pkg::ST_CMD: begin
            cmd_wr_en = 1'b1;
            state_in  = pwvm_pkg::ST_IDLE;
         end
         pwvm_pkg::ST_TICK: begin
            ram_rd_en = 1'b1;
            issue     = 1'b1;
            if (iss_last) begin
               state_in = pwvm_pkg::ST_DRAIN;
            end else begin
               iss_in = iss_ff + 1'b1;
            end
         end
         pwvm_pkg::ST_DRAIN: begin
            if (!b_vld_ff && !mix_busy) begin
               state_in = pwvm_pkg::ST_FINISH;
            end
         end
         pwvm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = pwvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwvm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_addr_ff <= iss_ff;
      if (cmd_load) begin
         cmd_action_ff <= req_action;
         cmd_voice_ff  <= VIDX_W'(req_voice);
         cmd_value_ff  <= req_value;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.growth        <= pwvm_pkg::GROWTH_RST;
         cfg_ff.shrink        <= pwvm_pkg::SHRINK_RST;
         cfg_ff.min_level     <= pwvm_pkg::MIN_LVL_RST;
         cfg_ff.max_level     <= pwvm_pkg::MAX_LVL_RST;
         cfg_ff.initial_level <= pwvm_pkg::INIT_LVL_RST;
      end else if (csr_we) begin
         case (csr_index)
            pwvm_pkg::CSR_GROWTH:   cfg_ff.growth        <= csr_wdata;
            pwvm_pkg::CSR_SHRINK:   cfg_ff.shrink        <= csr_wdata;
            pwvm_pkg::CSR_MIN_LVL:  cfg_ff.min_level     <= csr_wdata;
            pwvm_pkg::CSR_MAX_LVL:  cfg_ff.max_level     <= csr_wdata;
            pwvm_pkg::CSR_INIT_LVL: cfg_ff.initial_level <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- voice memory
   // Accesses never overlap on one entry: a command's write lands before the
   // next beat is taken, and a tick touches each voice exactly once.
   assign ent_level   = ram_rd_data[15:0];
   assign ent_growing = ram_rd_data[OFS_GROW];
   assign ent_phase   = ram_rd_data[OFS_PHASE +: PH_W];
   assign ent_step    = ram_rd_data[OFS_STEP +: PH_W];
   assign ent_gain    = ram_rd_data[OFS_GAIN +: 16];

   // step writes saturate so a single wrap always suffices
   assign step_sat = ({1'b0, cmd_value_ff} >= 17'(TABLE_DEPTH)) ? PH_W'(TABLE_DEPTH - 1)
                                                               : PH_W'(cmd_value_ff);

   always_comb begin
      cmd_level   = ent_level;
      cmd_growing = ent_growing;
      cmd_phase   = ent_phase;
      cmd_step    = ent_step;
      cmd_gain    = ent_gain;
      case (cmd_action_ff)
         pwvm_pkg::ACT_NOTE_ON: begin
            // restart only a voice that has decayed below the floor
            if (ent_level < cfg_ff.min_level) begin
               cmd_level = cfg_ff.initial_level;
               cmd_phase = '0;
            end
            cmd_growing = 1'b1;
         end
         pwvm_pkg::ACT_NOTE_OFF: cmd_growing = 1'b0;
         pwvm_pkg::ACT_SET_STEP: cmd_step    = step_sat;
         pwvm_pkg::ACT_SET_GAIN: cmd_gain    = cmd_value_ff;
         default: ;
      endcase
   end

   assign ram_wr_en   = cmd_wr_en | mix_wr_en;
   assign ram_wr_addr = cmd_wr_en ? cmd_voice_ff : mix_wr_addr;
   assign ram_wr_data = cmd_wr_en
                      ? {cmd_gain, cmd_step, cmd_phase, cmd_growing, cmd_level}
                      : {mix_wr_gain, mix_wr_step, mix_wr_phase, mix_wr_growing,
                         mix_wr_level};

   pwvm_voice_ram #(
      .DEPTH (VOICES),
      .WIDTH (ENT_W)
   ) u_voice_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   pwvm_sine_rom #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   pwvm_mix #(
      .VOICES      (VOICES),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .acc_clear  (acc_clear),
      .b_vld      (b_vld_ff),
      .b_addr     (b_addr_ff),
      .b_level    (ent_level),
      .b_growing  (ent_growing),
      .b_phase    (ent_phase),
      .b_step     (ent_step),
      .b_gain     (ent_gain),
      .rom_rd_en  (rom_rd_en),
      .rom_addr   (rom_addr),
      .rom_data   (rom_data),
      .wr_en      (mix_wr_en),
      .wr_addr    (mix_wr_addr),
      .wr_level   (mix_wr_level),
      .wr_growing (mix_wr_growing),
      .wr_phase   (mix_wr_phase),
      .wr_step    (mix_wr_step),
      .wr_gain    (mix_wr_gain),
      .acc        (mix_acc),
      .busy       (mix_busy)
   );

   // ---------------------------------------------------------------- output
   // floor(sum / 2^28) fits in 24 bits when all bits above the sample's
   // sign bit agree with it
   assign sign_bits     = mix_acc[ACC_W-1:SAT_LSB];
   assign fits          = (&sign_bits) | ~(|sign_bits);
   assign rsp_sample_in = fits ? mix_acc[SAT_LSB:pwvm_pkg::SUM_SHIFT]
                        : (mix_acc[ACC_W-1] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}});
   assign rsp_clip_in   = ~fits;
   assign rsp_valid_in  = rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_clip_ff   <= rsp_clip_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = rsp_clip_ff;

   // ---------------------------------------------------------------- checks
   `PWVM_ASSERT_IMPLY(a_wb_in_tick, mix_wr_en, (state_ff == pwvm_pkg::ST_TICK) || (state_ff == pwvm_pkg::ST_DRAIN))
   `PWVM_ASSERT_IMPLY(a_rsp_from_finish, $rose(rsp_tvalid), $past(state_ff == pwvm_pkg::ST_FINISH))
   `PWVM_ASSERT_NEXT(a_tick_clears_sum, req_tvalid && req_tready && (req_tuser == pwvm_pkg::ACT_TICK), (mix_acc == '0) && !mix_busy)
   `PWVM_ASSERT_IMPLY(a_clip_at_rail, rsp_tvalid && rsp_tuser, (rsp_tdata == 24'h7fffff) || (rsp_tdata == 24'h800000))

endmodule
